/* design/bba_pkg.sv */
package bba_pkg;

  localparam int unsigned MaxLevels = 8;
  localparam int unsigned LenW      = 27;
  localparam int unsigned NeedW     = 28;
  localparam int unsigned TopW      = 6;
  localparam int unsigned CfgW      = 7;
  localparam int unsigned CfgIdxW   = 2;

  typedef enum logic [1:0] {
    ND_ABSENT,
    ND_FREE,
    ND_FULL,
    ND_SPLIT
  } node_e;

  typedef enum logic [1:0] {
    RES_OK,
    RES_NOMEM,
    RES_BADFREE
  } status_e;

  typedef enum logic [1:0] {
    REG_BLOCK_LOG2,
    REG_LEVEL_COUNT,
    REG_HEADER_BYTES
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_SPLIT_A,
    S_SPLIT_B,
    S_MARK,
    S_FSRCH,
    S_MRG_RD,
    S_MRG_CK,
    S_MRG_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

/* design/bba_level_calc.sv */
module bba_level_calc import bba_pkg::*; #(
  parameter int unsigned LvW = 3
) (
  input  logic [NeedW-1:0] need_i,
  input  logic [TopW-1:0]  top_i,
  input  logic [LvW-1:0]   last_lv_i,
  output logic [LvW-1:0]   target_o,
  output logic             too_big_o
);

  logic [NeedW-1:0] m;
  logic [TopW-1:0]  c;
  logic [TopW-1:0]  i0;
  logic [TopW-1:0]  sl;

  // c = bit length of need-1, so that 2^k < need iff k < c
  always_comb begin
    m = need_i - NeedW'(1);
    c = '0;
    if (need_i != '0) begin
      for (int i = 0; i < NeedW; i++) begin
        if (m[i]) c = TopW'(i + 1);
      end
    end
    i0 = (top_i > c) ? (top_i - c) : '0;
    if (i0 > TopW'(last_lv_i)) target_o = last_lv_i;
    else                       target_o = LvW'(i0);
    sl = top_i - TopW'(target_o);
    too_big_o = (sl < c);
  end

endmodule

/* design/bba_node_mem.sv */
module bba_node_mem import bba_pkg::*; #(
  parameter int unsigned NodeW = MaxLevels
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  mem_ctl_t         ctl_i,
  input  logic [NodeW-1:0] waddr_i,
  input  node_e            wdata_i,
  input  logic [NodeW-1:0] raddr_i,
  output node_e            rdata_o
);

  localparam int unsigned Nodes = 1 << NodeW;

  node_e             mem_q [Nodes];
  logic [Nodes-1:0]  valid_q;
  node_e             rd_q;
  logic              rvalid_q;
  logic              rroot_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rd_q    <= mem_q[raddr_i];
      rroot_q <= (raddr_i == NodeW'(1));
    end
  end

  // entries never written since init read as the reset tree
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (ctl_i.wr_en) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rd_q : (rroot_q ? ND_FREE : ND_ABSENT);

endmodule

/* design/binary_buddy_allocator.sv */
// Allocate: node scan, one node read per cycle, then two writes per split level;
//   free: at most one read per level, then a buddy read and two writes per merge step.
// One request at a time; the node scan, one read per cycle, sets the pace.
// Reset and any register write leave one free root block; no clearing pass.
module binary_buddy_allocator import bba_pkg::*; #(
  parameter int unsigned MAX_LEVELS = MaxLevels
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [55:0]        s_axis_tdata,  // request_length[26:0], free_offset[53:27]
  input  logic               s_axis_tuser,  // operation
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,  // status[1:0], user_offset[28:2]
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  localparam int unsigned NW  = MAX_LEVELS;
  localparam int unsigned LVW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  logic [4:0] blk_log2_q;
  logic [3:0] lvl_cnt_q;
  logic [6:0] hdr_q;
  logic       init;

  always_comb begin
    init = 1'b0;
    if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_BLOCK_LOG2, REG_LEVEL_COUNT, REG_HEADER_BYTES: init = 1'b1;
        default: init = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_log2_q <= 5'd6;
      lvl_cnt_q  <= 4'd8;
      hdr_q      <= 7'd16;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_BLOCK_LOG2:   blk_log2_q <= cfg_wdata_i[4:0];
        REG_LEVEL_COUNT:  lvl_cnt_q  <= cfg_wdata_i[3:0];
        REG_HEADER_BYTES: hdr_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [4:0]      eff_log2;
  logic [4:0]      eff_lv;
  logic [TopW-1:0] top;
  logic [LVW-1:0]  last_lv;

  always_comb begin
    if (blk_log2_q < 5'd4)       eff_log2 = 5'd4;
    else if (blk_log2_q > 5'd20) eff_log2 = 5'd20;
    else                         eff_log2 = blk_log2_q;
    if (lvl_cnt_q == 4'd0)                      eff_lv = 5'd1;
    else if ({1'b0, lvl_cnt_q} > 5'(MAX_LEVELS)) eff_lv = 5'(MAX_LEVELS);
    else                                        eff_lv = {1'b0, lvl_cnt_q};
    top     = TopW'(eff_log2) + TopW'(eff_lv) - TopW'(1);
    last_lv = LVW'(eff_lv - 5'd1);
  end

  // request latch
  logic            op_q;
  logic [LenW-1:0] len_q;
  logic [LenW-1:0] off_q;

  logic [NeedW-1:0] need;
  logic [LVW-1:0]   target_w;
  logic             too_big_w;

  assign need = NeedW'(hdr_q) + NeedW'(len_q);

  bba_level_calc #(.LvW(LVW)) u_level_calc (
    .need_i   (need),
    .top_i    (top),
    .last_lv_i(last_lv),
    .target_o (target_w),
    .too_big_o(too_big_w)
  );

  mem_ctl_t      mctl;
  logic [NW-1:0] waddr;
  node_e         wdata;
  logic [NW-1:0] raddr;
  node_e         rdata;

  bba_node_mem #(.NodeW(NW)) u_node_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clear_i(init),
    .ctl_i  (mctl),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  state_e          state_q, state_d;
  logic [NW-1:0]   n_q, n_d;
  logic [LVW-1:0]  lv_q, lv_d;
  logic [LVW-1:0]  tgt_q, tgt_d;
  logic [NW-1:0]   sa_q, sa_d;
  logic            sdone_q, sdone_d;
  logic [NW-1:0]   ca_q, ca_d;
  logic            ck_q, ck_d;
  logic            cv_q, cv_d;
  logic            clast_q, clast_d;
  status_e         res_st_q, res_st_d;
  logic [LenW-1:0] res_off_q, res_off_d;
  logic            m_valid_q, m_valid_d;
  status_e         m_st_q, m_st_d;
  logic [LenW-1:0] m_off_q, m_off_d;

  // free-search candidate at level lv_q
  logic [63:0]     b64;
  logic [TopW-1:0] sl_f;
  logic [63:0]     p64;
  logic            aligned;
  logic            in_range;
  logic [NW-1:0]   cand_addr;
  logic            lv_end;
  logic [NW-1:0]   p_blk;
  logic [TopW-1:0] sl_t;

  always_comb begin
    b64       = 64'(off_q) - 64'(hdr_q);
    sl_f      = top - TopW'(lv_q);
    aligned   = ((b64 & ((64'd1 << sl_f) - 64'd1)) == 64'd0);
    p64       = b64 >> sl_f;
    in_range  = ((p64 >> lv_q) == 64'd0);
    cand_addr = NW'((64'd1 << lv_q) | p64);
    lv_end    = (sa_q == NW'((64'd1 << ((LVW + 1)'(lv_q) + (LVW + 1)'(1))) - 64'd1));
    p_blk     = n_q - NW'(64'd1 << tgt_q);
    sl_t      = top - TopW'(tgt_q);
  end

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    lv_d      = lv_q;
    tgt_d     = tgt_q;
    sa_d      = sa_q;
    sdone_d   = sdone_q;
    ca_d      = ca_q;
    ck_d      = ck_q;
    cv_d      = cv_q;
    clast_d   = clast_q;
    res_st_d  = res_st_q;
    res_off_d = res_off_q;
    m_valid_d = m_axis_tready ? 1'b0 : m_valid_q;
    m_st_d    = m_st_q;
    m_off_d   = m_off_q;
    mctl      = '0;
    waddr     = n_q;
    wdata     = ND_FREE;
    raddr     = sa_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) state_d = S_PREP;
      end
      S_PREP: begin
        res_off_d = '0;
        sdone_d   = 1'b0;
        ck_d      = 1'b0;
        cv_d      = 1'b0;
        if (!op_q) begin
          if (too_big_w) begin
            res_st_d = RES_NOMEM;
            state_d  = S_DONE;
          end else begin
            tgt_d   = target_w;
            lv_d    = target_w;
            sa_d    = NW'(64'd1 << target_w);
            state_d = S_SCAN;
          end
        end else if (off_q < LenW'(hdr_q)) begin
          res_st_d = RES_BADFREE;
          state_d  = S_DONE;
        end else begin
          lv_d    = '0;
          state_d = S_FSRCH;
        end
      end
      S_SCAN: begin
        // issue one node read per cycle, lowest address first, deeper level first
        if (!sdone_q) begin
          mctl.rd_en = 1'b1;
          raddr      = sa_q;
          ca_d       = sa_q;
          ck_d       = 1'b1;
          cv_d       = 1'b1;
          clast_d    = (sa_q == NW'(1));
          if (lv_end) begin
            if (lv_q == '0) begin
              sdone_d = 1'b1;
            end else begin
              lv_d = lv_q - LVW'(1);
              sa_d = NW'(64'd1 << (lv_q - LVW'(1)));
            end
          end else begin
            sa_d = sa_q + NW'(1);
          end
        end else begin
          ck_d = 1'b0;
        end
        if (ck_q) begin
          if (rdata == ND_FREE) begin
            n_d     = ca_q;
            state_d = S_MARK;
            // level of the found node: highest set bit of its index
            for (int i = 0; i < NW; i++) begin
              if (ca_q[i]) lv_d = LVW'(i);
            end
            ck_d = 1'b0;
            if (lv_d != tgt_q) state_d = S_SPLIT_A;
          end else if (clast_q) begin
            res_st_d = RES_NOMEM;
            state_d  = S_DONE;
          end
        end
      end
      S_SPLIT_A: begin
        mctl.wr_en = 1'b1;
        waddr      = n_q;
        wdata      = ND_SPLIT;
        state_d    = S_SPLIT_B;
      end
      S_SPLIT_B: begin
        mctl.wr_en = 1'b1;
        waddr      = NW'({n_q, 1'b1});
        wdata      = ND_FREE;
        n_d        = NW'({n_q, 1'b0});
        lv_d       = lv_q + LVW'(1);
        if ((LVW + 1)'(lv_q) + (LVW + 1)'(1) == (LVW + 1)'(tgt_q)) state_d = S_MARK;
        else                                                    state_d = S_SPLIT_A;
      end
      S_MARK: begin
        mctl.wr_en = 1'b1;
        waddr      = n_q;
        wdata      = ND_FULL;
        res_st_d   = RES_OK;
        res_off_d  = LenW'((64'(p_blk) << sl_t) + 64'(hdr_q));
        state_d    = S_DONE;
      end
      S_FSRCH: begin
        if (!sdone_q) begin
          mctl.rd_en = aligned && in_range;
          raddr      = cand_addr;
          ca_d       = cand_addr;
          ck_d       = 1'b1;
          cv_d       = aligned && in_range;
          clast_d    = (lv_q == last_lv);
          if (lv_q == last_lv) sdone_d = 1'b1;
          else                 lv_d    = lv_q + LVW'(1);
        end else begin
          ck_d = 1'b0;
        end
        if (ck_q) begin
          if (cv_q && rdata == ND_FULL) begin
            n_d     = ca_q;
            ck_d    = 1'b0;
            state_d = S_MRG_RD;
          end else if (clast_q) begin
            res_st_d = RES_BADFREE;
            state_d  = S_DONE;
          end
        end
      end
      S_MRG_RD: begin
        if (n_q == NW'(1)) begin
          mctl.wr_en = 1'b1;
          waddr      = n_q;
          wdata      = ND_FREE;
          res_st_d   = RES_OK;
          state_d    = S_DONE;
        end else begin
          mctl.rd_en = 1'b1;
          raddr      = n_q ^ NW'(1);
          state_d    = S_MRG_CK;
        end
      end
      S_MRG_CK: begin
        mctl.wr_en = 1'b1;
        if (rdata == ND_FREE) begin
          waddr   = n_q ^ NW'(1);
          wdata   = ND_ABSENT;
          state_d = S_MRG_WR;
        end else begin
          waddr    = n_q;
          wdata    = ND_FREE;
          res_st_d = RES_OK;
          state_d  = S_DONE;
        end
      end
      S_MRG_WR: begin
        mctl.wr_en = 1'b1;
        waddr      = n_q;
        wdata      = ND_ABSENT;
        n_d        = n_q >> 1;
        state_d    = S_MRG_RD;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_st_d    = res_st_q;
          m_off_d   = res_off_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= s_axis_tuser;
      len_q <= s_axis_tdata[26:0];
      off_q <= s_axis_tdata[53:27];
    end
    n_q       <= n_d;
    lv_q      <= lv_d;
    tgt_q     <= tgt_d;
    sa_q      <= sa_d;
    ca_q      <= ca_d;
    res_st_q  <= res_st_d;
    res_off_q <= res_off_d;
    m_st_q    <= m_st_d;
    m_off_q   <= m_off_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sdone_q   <= 1'b0;
      ck_q      <= 1'b0;
      cv_q      <= 1'b0;
      clast_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sdone_q   <= sdone_d;
      ck_q      <= ck_d;
      cv_q      <= cv_d;
      clast_q   <= clast_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_off_q, m_st_q};

endmodule
